FILE: design/mbb_pkg.sv
package mbb_pkg;

  // Screen geometry in pixels.
  localparam int unsigned SCREEN_WIDTH  = 640;
  localparam int unsigned SCREEN_HEIGHT = 480;

  // Field widths.
  localparam int unsigned COORD_W = 10;
  localparam int unsigned COL_W   = 11;
  localparam int unsigned ADDR_W  = 18;
  localparam int unsigned BASE_W  = ADDR_W + 1;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned PIX_N   = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // Job queue geometry.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  // Request kinds.
  typedef enum logic {
    REQ_HEADER = 1'b0,
    REQ_DATA   = 1'b1
  } req_type_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_ENABLE = 3'd0,
    CFG_CLIP_LEFT   = 3'd1,
    CFG_CLIP_TOP    = 3'd2,
    CFG_CLIP_SPAN_X = 3'd3,
    CFG_CLIP_SPAN_Y = 3'd4
  } cfg_index_e;

  // One classified bitmap byte: which of its eight pixels get written.
  typedef struct packed {
    logic [BASE_W-1:0]  row_base;
    logic [COL_W-1:0]   column;
    logic [PIX_N-1:0]   mask;
    logic [COLOR_W-1:0] color;
  } job_t;

  // Handshake between the queue and its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: design/mbb_req_if.sv
interface mbb_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [mbb_pkg::COORD_W-1:0]       x_pos;
  logic [mbb_pkg::COORD_W-1:0]       y_pos;
  logic [mbb_pkg::COORD_W-1:0]       blit_width;
  logic [mbb_pkg::COORD_W-1:0]       blit_height;
  logic [mbb_pkg::COLOR_W-1:0]       fg_color;
  logic [7:0]                        bitmap_byte;

  modport source (
    output valid, req_type, x_pos, y_pos, blit_width, blit_height, fg_color, bitmap_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, x_pos, y_pos, blit_width, blit_height, fg_color, bitmap_byte,
    output ready
  );
endinterface

FILE: design/mbb_wr_if.sv
interface mbb_wr_if;
  logic                        valid;
  logic                        ready;
  logic [mbb_pkg::ADDR_W-1:0]  word_address;
  logic [mbb_pkg::COLOR_W-1:0] pixel_color;
  logic                        upper_half;
  logic                        last;

  modport source (
    output valid, word_address, pixel_color, upper_half, last,
    input  ready
  );
  modport sink (
    input  valid, word_address, pixel_color, upper_half, last,
    output ready
  );
endinterface

FILE: design/mbb_front.sv
module mbb_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mbb_req_if.sink                         req,
  input  logic                            cfg_we_i,
  input  logic [mbb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mbb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  mbb_pkg::q_status_t              q_status_i,
  output logic                            push_o,
  output mbb_pkg::job_t                   job_o
);

  localparam int unsigned CW  = mbb_pkg::COL_W;
  localparam int unsigned XW  = mbb_pkg::COORD_W;
  localparam int unsigned PW  = 2 * CW;

  // Clip registers.
  logic          clip_en_q;
  logic [XW-1:0] clip_left_q, clip_top_q, clip_span_x_q, clip_span_y_q;

  // Blit state.
  logic [XW-1:0]              start_col_q, start_col_d;
  logic [CW-1:0]              cur_col_q, cur_col_d;
  logic [CW-1:0]              cur_row_q, cur_row_d;
  logic [XW-1:0]              rows_left_q, rows_left_d;
  logic [7:0]                 byte_in_row_q, byte_in_row_d;
  logic [7:0]                 bytes_per_row_q, bytes_per_row_d;
  logic [CW-1:0]              col_limit_q, col_limit_d;
  logic [mbb_pkg::COLOR_W-1:0] color_q, color_d;

  logic                 accept;
  logic                 is_data;
  logic [CW-1:0]        lim_sum;
  logic [CW-1:0]        wpad;
  logic [7:0]           byte_next;
  logic [CW-1:0]        clip_right, clip_bottom;
  logic                 row_ok;
  logic                 row_in_clip;
  logic [CW:0]          col_k;
  logic [mbb_pkg::PIX_N-1:0] mask;
  logic [PW-1:0]        row_prod;

  // The front stalls only when the job queue has no room.
  assign req.ready = !q_status_i.full;
  assign accept    = req.valid && req.ready;
  assign is_data   = (req.req_type == mbb_pkg::REQ_DATA);

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_en_q     <= 1'b0;
      clip_left_q   <= '0;
      clip_top_q    <= '0;
      clip_span_x_q <= '0;
      clip_span_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mbb_pkg::CFG_CLIP_ENABLE: clip_en_q     <= cfg_data_i[0];
        mbb_pkg::CFG_CLIP_LEFT:   clip_left_q   <= cfg_data_i;
        mbb_pkg::CFG_CLIP_TOP:    clip_top_q    <= cfg_data_i;
        mbb_pkg::CFG_CLIP_SPAN_X: clip_span_x_q <= cfg_data_i;
        mbb_pkg::CFG_CLIP_SPAN_Y: clip_span_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Classify the eight pixels of the current byte.
  always_comb begin
    clip_right  = {1'b0, clip_left_q} + {1'b0, clip_span_x_q};
    clip_bottom = {1'b0, clip_top_q} + {1'b0, clip_span_y_q};
    row_ok      = cur_row_q < CW'(mbb_pkg::SCREEN_HEIGHT);
    row_in_clip = clip_en_q && (cur_row_q >= {1'b0, clip_top_q}) &&
                  (cur_row_q <= clip_bottom);
    col_k       = '0;
    mask        = '0;
    for (int k = 0; k < mbb_pkg::PIX_N; k++) begin
      col_k   = {1'b0, cur_col_q} + (CW + 1)'(k);
      mask[k] = req.bitmap_byte[mbb_pkg::PIX_N-1-k] && row_ok &&
                (col_k < {1'b0, col_limit_q}) &&
                !(row_in_clip && (col_k >= {2'b0, clip_left_q}) &&
                  (col_k <= {1'b0, clip_right}));
    end
  end

  // Row base address for the queue entry.
  assign row_prod = PW'(cur_row_q) * PW'(mbb_pkg::SCREEN_WIDTH);

  assign job_o.row_base = row_prod[mbb_pkg::BASE_W-1:0];
  assign job_o.column   = cur_col_q;
  assign job_o.mask     = mask;
  assign job_o.color    = color_q;
  assign push_o = accept && is_data && (rows_left_q != '0) && (mask != '0);

  // Next blit state.
  always_comb begin
    start_col_d     = start_col_q;
    cur_col_d       = cur_col_q;
    cur_row_d       = cur_row_q;
    rows_left_d     = rows_left_q;
    byte_in_row_d   = byte_in_row_q;
    bytes_per_row_d = bytes_per_row_q;
    col_limit_d     = col_limit_q;
    color_d         = color_q;
    lim_sum         = {1'b0, req.x_pos} + {1'b0, req.blit_width};
    wpad            = {1'b0, req.blit_width} + CW'(7);
    byte_next       = byte_in_row_q + 8'd1;
    if (accept) begin
      if (!is_data) begin
        start_col_d     = req.x_pos;
        cur_col_d       = {1'b0, req.x_pos};
        cur_row_d       = {1'b0, req.y_pos};
        bytes_per_row_d = wpad[CW-1:3];
        rows_left_d     = (req.blit_width == '0) ? '0 : req.blit_height;
        byte_in_row_d   = '0;
        col_limit_d     = (lim_sum > CW'(mbb_pkg::SCREEN_WIDTH)) ?
                          CW'(mbb_pkg::SCREEN_WIDTH) : lim_sum;
        color_d         = req.fg_color;
      end else if (rows_left_q != '0) begin
        if (byte_next >= bytes_per_row_q) begin
          byte_in_row_d = '0;
          cur_col_d     = {1'b0, start_col_q};
          cur_row_d     = cur_row_q + CW'(1);
          rows_left_d   = rows_left_q - XW'(1);
        end else begin
          byte_in_row_d = byte_next;
          cur_col_d     = cur_col_q + CW'(mbb_pkg::PIX_N);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_col_q     <= '0;
      cur_col_q       <= '0;
      cur_row_q       <= '0;
      rows_left_q     <= '0;
      byte_in_row_q   <= '0;
      bytes_per_row_q <= '0;
      col_limit_q     <= '0;
      color_q         <= '0;
    end else begin
      start_col_q     <= start_col_d;
      cur_col_q       <= cur_col_d;
      cur_row_q       <= cur_row_d;
      rows_left_q     <= rows_left_d;
      byte_in_row_q   <= byte_in_row_d;
      bytes_per_row_q <= bytes_per_row_d;
      col_limit_q     <= col_limit_d;
      color_q         <= color_d;
    end
  end

endmodule

FILE: design/mbb_queue.sv
module mbb_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mbb_pkg::job_t      push_job_i,
  input  logic               pop_i,
  output mbb_pkg::job_t      pop_job_o,
  output mbb_pkg::q_status_t status_o
);

  localparam int unsigned PTR_W = mbb_pkg::Q_PTR_W;
  localparam int unsigned CNT_W = mbb_pkg::Q_CNT_W;

  mbb_pkg::job_t           slot_q [mbb_pkg::Q_DEPTH];
  logic [PTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    do_push, do_pop;

  assign status_o.full  = (count_q == CNT_W'(mbb_pkg::Q_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign pop_job_o = slot_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

FILE: design/mbb_back.sv
module mbb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mbb_pkg::q_status_t q_status_i,
  input  mbb_pkg::job_t      job_i,
  output logic               pop_o,
  mbb_wr_if.source           wr
);

  localparam int unsigned N  = mbb_pkg::PIX_N;
  localparam int unsigned IW = $clog2(N);
  localparam int unsigned BW = mbb_pkg::BASE_W;

  mbb_pkg::job_t job_q;
  logic          busy_q;
  logic          out_valid_q;
  logic [mbb_pkg::ADDR_W-1:0]  addr_q;
  logic [mbb_pkg::COLOR_W-1:0] color_q;
  logic          upper_q, last_q;

  logic          advance, emit, load;
  logic [IW-1:0] idx;
  logic [N-1:0]  rem;
  logic [BW-1:0] pix_addr;

  // Leftmost pending pixel goes first.
  always_comb begin
    idx = '0;
    for (int k = N - 1; k >= 0; k--) begin
      if (job_q.mask[k]) begin
        idx = IW'(k);
      end
    end
    rem      = job_q.mask;
    rem[idx] = 1'b0;
    pix_addr = job_q.row_base + BW'(job_q.column) + BW'(idx);
  end

  assign advance = !out_valid_q || wr.ready;
  assign emit    = busy_q && advance;
  assign load    = (!busy_q || (emit && (rem == '0))) && !q_status_i.empty;
  assign pop_o   = load;

  // Job register and output beat valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (wr.ready) begin
        out_valid_q <= 1'b0;
      end
      if (load) begin
        busy_q <= 1'b1;
      end else if (emit) begin
        busy_q <= (rem != '0);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end else if (emit) begin
      job_q.mask <= rem;
    end
    if (emit) begin
      addr_q  <= pix_addr[BW-1:1];
      color_q <= job_q.color;
      upper_q <= !pix_addr[0];
      last_q  <= (rem == '0);
    end
  end

  assign wr.valid        = out_valid_q;
  assign wr.word_address = addr_q;
  assign wr.pixel_color  = color_q;
  assign wr.upper_half   = upper_q;
  assign wr.last         = last_q;

endmodule

FILE: design/mono_bitmap_blit_clipped_top.sv
// Monochrome bitmap blit with an exclusion rectangle.
// The in_i channel takes header beats (req_type 0: position, size, color) and
// bitmap beats (req_type 1: eight pixels, bit 7 leftmost, rows padded to bytes).
// The out_o channel gives one beat per framebuffer half-word write, with last
// set on the final write caused by a bitmap byte; headers give no beats.
// The cfg port writes the clip registers; write it only while the block idles.
// Every input beat is accepted whenever the two-entry job queue has room. The
// first write of a byte passes the queue slot, the job register and the output
// register after its beat is accepted. The write unit gives one beat per cycle
// while the receiver takes them; a byte gives one write per surviving pixel (up
// to eight), and fully transparent or clipped bytes never enter the queue.
// When the receiver stalls, the output register holds its beat, the write
// unit waits, the queue fills and then in_i.ready drops.
// Reset clears the clip registers, ends any blit and empties the queue.
module mono_bitmap_blit_clipped_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mbb_req_if.sink                         in_i,
  mbb_wr_if.source                        out_o,
  input  logic                            cfg_we_i,
  input  logic [mbb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mbb_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  mbb_pkg::q_status_t q_status;
  mbb_pkg::job_t      push_job, pop_job;
  logic               push, pop;

  // Byte classification and blit state.
  mbb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .job_o       (push_job)
  );

  // Decoupling queue.
  mbb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .status_o   (q_status)
  );

  // Pixel write generation.
  mbb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .job_i      (pop_job),
    .pop_o      (pop),
    .wr         (out_o)
  );

endmodule
